FILE: rtl/pclc_pkg.sv
// ----------------------------------------------------------------------------
// pclc_pkg
// types and constants shared by the parallel camera line capture block
// ----------------------------------------------------------------------------
`default_nettype none

package pclc_pkg;

  // register map (byte address = 4 * index)
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic CFG_IDX_WORDS = 1'b0;
  localparam logic CFG_IDX_LINES = 1'b1;

  localparam int unsigned WPL_W = 11;
  localparam int unsigned LPF_W = 13;

  localparam logic [WPL_W-1:0] WPL_RESET = 11'd320;
  localparam logic [LPF_W-1:0] LPF_RESET = 13'd960;

  localparam int unsigned WORD_IDX_W = 10;
  localparam int unsigned LINE_IDX_W = 12;

  // one sample of the camera pins, or a host start request
  typedef struct packed {
    logic       func;
    logic       vsync;
    logic       hsync;
    logic       pclk;
    logic [7:0] pixel_byte;
  } pclc_in_t;

  // one packed word of a line
  typedef struct packed {
    logic [31:0]           packed_word;
    logic [WORD_IDX_W-1:0] word_index;
    logic [LINE_IDX_W-1:0] line_index;
    logic                  buffer_select;
    logic                  line_done;
    logic                  frame_done;
  } pclc_out_t;

  // raw register contents as seen by the capture logic
  typedef struct packed {
    logic [WPL_W-1:0] words_per_line;
    logic [LPF_W-1:0] lines_per_frame;
  } pclc_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/pclc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pclc_cfg_regs
// apb register file: words per line and lines per frame
// ----------------------------------------------------------------------------
`default_nettype none

module pclc_cfg_regs
  import pclc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output pclc_cfg_t                  cfg
);

  logic [WPL_W-1:0] wpl_r;
  logic [LPF_W-1:0] lpf_r;
  logic             wr_en;
  logic             idx;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpl_r <= WPL_RESET;
      lpf_r <= LPF_RESET;
    end else if (wr_en) begin
      unique case (idx)
        CFG_IDX_WORDS: wpl_r <= pwdata[WPL_W-1:0];
        CFG_IDX_LINES: lpf_r <= pwdata[LPF_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_IDX_WORDS: prdata = 32'(wpl_r);
      CFG_IDX_LINES: prdata = 32'(lpf_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.words_per_line  = wpl_r;
  assign cfg.lines_per_frame = lpf_r;

endmodule

`default_nettype wire

FILE: rtl/pclc_capture.sv
// ----------------------------------------------------------------------------
// pclc_capture
// frame sequencer, pixel clock edge detect, byte packing and line counters
// ----------------------------------------------------------------------------
`default_nettype none

module pclc_capture
  import pclc_pkg::*;
#(
  parameter int unsigned MAX_WORDS_PER_LINE = 1024,
  parameter int unsigned MAX_LINES          = 4096
)
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_valid,
  input  pclc_in_t       item,
  input  pclc_cfg_t      cfg,
  output logic           res_valid,
  output pclc_out_t      res
);

  localparam int unsigned WCW = (MAX_WORDS_PER_LINE > 1) ? $clog2(MAX_WORDS_PER_LINE) : 1;
  localparam int unsigned LCW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  // compare widths: hold count + 1, the raw register and the maximum
  localparam int unsigned WKW = (WCW + 1 > WPL_W + 1) ? WCW + 1 : WPL_W + 1;
  localparam int unsigned LKW = (LCW + 1 > LPF_W + 1) ? LCW + 1 : LPF_W + 1;
  localparam int unsigned WXW = (WCW > WORD_IDX_W) ? WCW : WORD_IDX_W;
  localparam int unsigned LXW = (LCW > LINE_IDX_W) ? LCW : LINE_IDX_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_LOW,
    PH_WAIT_HIGH,
    PH_CAPTURE
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic            start_r, start_nxt;
  logic            gate_r, gate_nxt;
  logic            low_seen_r, low_seen_nxt;
  logic [1:0]      bc_r, bc_nxt;
  logic [23:0]     partial_r, partial_nxt;
  logic [WCW-1:0]  wc_r, wc_nxt;
  logic [LCW-1:0]  lc_r, lc_nxt;
  logic            buf_r, buf_nxt;

  logic [WKW-1:0]  word_lim;
  logic [LKW-1:0]  line_lim;
  logic            ld, fd;
  logic [WXW-1:0]  wc_ext;
  logic [LXW-1:0]  lc_ext;

  // zero acts as one, large values saturate
  always_comb begin
    if (cfg.words_per_line == '0) begin
      word_lim = WKW'(1);
    end else if (WKW'(cfg.words_per_line) > WKW'(MAX_WORDS_PER_LINE)) begin
      word_lim = WKW'(MAX_WORDS_PER_LINE);
    end else begin
      word_lim = WKW'(cfg.words_per_line);
    end
    if (cfg.lines_per_frame == '0) begin
      line_lim = LKW'(1);
    end else if (LKW'(cfg.lines_per_frame) > LKW'(MAX_LINES)) begin
      line_lim = LKW'(MAX_LINES);
    end else begin
      line_lim = LKW'(cfg.lines_per_frame);
    end
  end

  assign ld = (WKW'(wc_r) + WKW'(1)) >= word_lim;
  assign fd = ld && ((LKW'(lc_r) + LKW'(1)) >= line_lim);

  assign wc_ext = WXW'(wc_r);
  assign lc_ext = LXW'(lc_r);

  always_comb begin
    phase_nxt    = phase_r;
    start_nxt    = start_r;
    gate_nxt     = gate_r;
    low_seen_nxt = low_seen_r;
    bc_nxt       = bc_r;
    partial_nxt  = partial_r;
    wc_nxt       = wc_r;
    lc_nxt       = lc_r;
    buf_nxt      = buf_r;
    res_valid    = 1'b0;

    res.packed_word   = {partial_r, item.pixel_byte};
    res.word_index    = wc_ext[WORD_IDX_W-1:0];
    res.line_index    = lc_ext[LINE_IDX_W-1:0];
    res.buffer_select = buf_r;
    res.line_done     = ld;
    res.frame_done    = fd;

    if (item_valid) begin
      if (item.func) begin
        start_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (start_r) begin
              start_nxt = 1'b0;
              phase_nxt = PH_WAIT_LOW;
            end
          end
          PH_WAIT_LOW: begin
            if (!item.vsync) phase_nxt = PH_WAIT_HIGH;
          end
          PH_WAIT_HIGH: begin
            if (item.vsync) begin
              phase_nxt    = PH_CAPTURE;
              gate_nxt     = 1'b0;
              low_seen_nxt = 1'b0;
              bc_nxt       = '0;
              partial_nxt  = '0;
              wc_nxt       = '0;
              lc_nxt       = '0;
            end
          end
          PH_CAPTURE: begin
            // hsync opens the gate and that sample's pclk counts at once
            if (gate_r || item.hsync) begin
              gate_nxt = 1'b1;
              if (!item.pclk) begin
                low_seen_nxt = 1'b1;
              end else if (low_seen_r) begin
                low_seen_nxt = 1'b0;
                if (bc_r != 2'd3) begin
                  partial_nxt = {partial_r[15:0], item.pixel_byte};
                  bc_nxt      = bc_r + 2'd1;
                end else begin
                  res_valid   = 1'b1;
                  bc_nxt      = '0;
                  partial_nxt = '0;
                  gate_nxt    = 1'b0;
                  if (ld) begin
                    wc_nxt  = '0;
                    buf_nxt = !buf_r;
                    if (fd) begin
                      lc_nxt    = '0;
                      phase_nxt = PH_IDLE;
                    end else begin
                      lc_nxt = lc_r + LCW'(1);
                    end
                  end else begin
                    wc_nxt = wc_r + WCW'(1);
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      start_r    <= 1'b0;
      gate_r     <= 1'b0;
      low_seen_r <= 1'b0;
      bc_r       <= '0;
      partial_r  <= '0;
      wc_r       <= '0;
      lc_r       <= '0;
      buf_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      start_r    <= start_nxt;
      gate_r     <= gate_nxt;
      low_seen_r <= low_seen_nxt;
      bc_r       <= bc_nxt;
      partial_r  <= partial_nxt;
      wc_r       <= wc_nxt;
      lc_r       <= lc_nxt;
      buf_r      <= buf_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/parallel_camera_line_capture.sv
// ----------------------------------------------------------------------------
// parallel_camera_line_capture
// parallel camera port capture: vsync/hsync/pclk sampling into packed words
// ----------------------------------------------------------------------------
// Each beat on the input channel is either one sample of the camera pins or a
// host start request. The block takes one beat every clock cycle as long as
// the result side keeps up; a beat passes through an input register and the
// capture state update, and its word (if it completes one) is then loaded into
// the output register. The rate is set by the single pass of the capture
// state update, which is done once per beat. After a
// start request the block waits for vsync low then high, then packs four
// bytes per word (first byte in bits 31:24), one byte per rising pclk edge,
// each word opened by hsync high. Every completed word comes out with its
// word and line index, the line buffer flag and line/frame done marks.
// Register 0 (byte address 0) is words per line, register 1 (byte address 4)
// is lines per frame; zero acts as one and large values saturate at the
// maximum parameters. Write the registers only while no beat is in flight;
// a count already at or past a new, smaller limit ends its line or frame on
// the next word.
// ----------------------------------------------------------------------------
`default_nettype none

module parallel_camera_line_capture
  import pclc_pkg::*;
#(
  parameter int unsigned MAX_WORDS_PER_LINE = 1024,
  parameter int unsigned MAX_LINES          = 4096
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  pclc_in_t                   in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pclc_out_t                  out_data,
  // configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready
);

  pclc_cfg_t  cfg;

  // input register
  logic       s1_valid_r;
  pclc_in_t   s1_item_r;

  // result register
  logic       out_valid_r;
  pclc_out_t  out_data_r;

  logic       advance;
  logic       s1_fire;
  logic       in_accept;
  logic       res_valid;
  pclc_out_t  res;

  pclc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // the result register is free when empty or being taken this cycle
  assign advance   = !(out_valid_r && out_stall);
  assign s1_fire   = s1_valid_r && advance;
  // input register refills while its beat moves on
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  pclc_capture #(
    .MAX_WORDS_PER_LINE (MAX_WORDS_PER_LINE),
    .MAX_LINES          (MAX_LINES)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_fire),
    .item       (s1_item_r),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_fire && res_valid;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (s1_fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a frame can only end on the last word of a line
  a_frame_on_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_done |-> out_data_r.line_done)
    else $error("frame_done without line_done");

  // input is only held off while a full result register is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a stalled result");

  // a beat held in the input register is not lost or overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && $stable(s1_item_r))
    else $error("held input beat changed");

  // a result register that is stalled keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire
